// ===== hdl/mfa_pkg.sv =====
// ----------------------------------------------------------------------------
// mfa_pkg
// Shared types and codes for the mixed fraction arithmetic unit: the request
// and response words, action and status codes, and the sign-magnitude type.
// ----------------------------------------------------------------------------
package mfa_pkg;

  // Intermediate magnitudes and the shared multiplier's operand width.
  localparam int MAG_W = 64;
  localparam int MUL_W = 32;
  localparam int CNT_W = $clog2(MAG_W);

  // Action codes.
  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_MUL = 3'd2;
  localparam logic [2:0] ACT_DIV = 3'd3;
  localparam logic [2:0] ACT_CMP = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [15:0] left_whole;
    logic signed [15:0] left_num;
    logic [14:0]        left_den;
    logic signed [15:0] right_whole;
    logic signed [15:0] right_num;
    logic [14:0]        right_den;
  } req_t;

  typedef struct packed {
    logic signed [31:0] res_whole;
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               is_less;
    logic               is_equal;
    logic               is_greater;
    logic [1:0]         status;
  } rsp_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } sm_t;

endpackage

// ===== hdl/mfa_mul.sv =====
// ----------------------------------------------------------------------------
// mfa_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module mfa_mul (
  input  logic                       clk,
  input  logic [mfa_pkg::MUL_W-1:0]  a,
  input  logic [mfa_pkg::MUL_W-1:0]  b,
  output logic [mfa_pkg::MAG_W-1:0]  p
);
  import mfa_pkg::*;

  // The product is registered and lands in the cycle after the operands are presented.
  always_ff @(posedge clk) begin
    p <= MAG_W'(a) * MAG_W'(b);
  end

endmodule

// ===== hdl/mfa_div.sv =====
// ----------------------------------------------------------------------------
// mfa_div
// Restoring divider, one quotient bit per cycle. Gives quotient and
// remainder of two unsigned magnitudes after one pass over all bits.
// ----------------------------------------------------------------------------
module mfa_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [mfa_pkg::MAG_W-1:0]  dividend,
  input  logic [mfa_pkg::MAG_W-1:0]  divisor,
  output logic [mfa_pkg::MAG_W-1:0]  quotient,
  output logic [mfa_pkg::MAG_W-1:0]  remainder,
  output logic                       done
);
  import mfa_pkg::*;

  logic [MAG_W-1:0] quo;
  logic [MAG_W-1:0] rem;
  logic [MAG_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [MAG_W:0]   trial;
  logic [MAG_W:0]   diff;
  logic             fits;

  // One trial subtraction per cycle.
  always_comb begin
    trial = {rem, quo[MAG_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = (trial >= {1'b0, dvs});
  end

  // Shift the dividend through and build the quotient bit by bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        quo <= dividend;
        rem <= '0;
        dvs <= divisor;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        quo <= {quo[MAG_W-2:0], fits};
        rem <= fits ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MAG_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== hdl/mfa_gcd.sv =====
// ----------------------------------------------------------------------------
// mfa_gcd
// Binary greatest common divisor: one shift or subtract per cycle, then the
// common power of two is shifted back in one bit per cycle.
// ----------------------------------------------------------------------------
module mfa_gcd (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [mfa_pkg::MAG_W-1:0]  a,
  input  logic [mfa_pkg::MAG_W-1:0]  b,
  output logic [mfa_pkg::MAG_W-1:0]  g,
  output logic                       done
);
  import mfa_pkg::*;

  logic [MAG_W-1:0] x;
  logic [MAG_W-1:0] y;
  logic [CNT_W-1:0] k;
  logic             run;
  logic             back;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      back <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        x    <= a;
        y    <= b;
        k    <= '0;
        run  <= 1'b1;
        back <= 1'b0;
      end else if (run && !back) begin
        // Reduce until one value is zero; the other is the gcd less its shared factors of two.
        if (x == '0) begin
          x    <= y;
          back <= 1'b1;
        end else if (y == '0) begin
          back <= 1'b1;
        end else if (!x[0] && !y[0]) begin
          x <= x >> 1;
          y <= y >> 1;
          k <= k + 1'b1;
        end else if (!x[0]) begin
          x <= x >> 1;
        end else if (!y[0]) begin
          y <= y >> 1;
        end else if (x >= y) begin
          x <= x - y;
        end else begin
          y <= y - x;
        end
      end else if (run) begin
        // Restore the shared factors of two.
        if (k == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          x <= x << 1;
          k <= k - 1'b1;
        end
      end
    end
  end

  assign g = x;

endmodule

// ===== hdl/mixed_fraction_alu.sv =====
// ----------------------------------------------------------------------------
// mixed_fraction_alu
// Exact add, subtract, multiply, divide and compare of two mixed fractions.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Busy then stays high
// until the result word is shown on rsp with done high for one cycle. Busy
// falls in that same cycle, and the receiver must take the word in that
// cycle. Divide by zero and unknown actions give their result from state P1,
// after the operand setup, and compare gives it from state P4, without the
// divider. The arithmetic actions run the multiplier steps (states MW1 to
// P4), then three full 64-bit passes through the shared restoring divider
// (whole part, reduced numerator, reduced denominator). A binary gcd runs
// between the first and second pass and does one shift or subtract per cycle.
// Its length depends on the operands; divide has the widest denominator.
// ----------------------------------------------------------------------------
module mixed_fraction_alu #(
  parameter int OPERAND_WIDTH = 16,
  parameter int RESULT_WIDTH  = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  mfa_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output mfa_pkg::rsp_t rsp
);
  import mfa_pkg::*;

  localparam logic [MAG_W-1:0] OW_MASK  = (MAG_W'(1) << OPERAND_WIDTH) - MAG_W'(1);
  localparam logic [MAG_W-1:0] DEN_MASK = (MAG_W'(1) << (OPERAND_WIDTH - 1)) - MAG_W'(1);
  localparam logic [MAG_W-1:0] LIM      = (MAG_W'(1) << (RESULT_WIDTH - 1)) - MAG_W'(1);
  localparam logic [MAG_W-1:0] LIM_P1   = LIM + MAG_W'(1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MW1  = 4'd1;
  localparam logic [3:0] S_MW2  = 4'd2;
  localparam logic [3:0] S_MW3  = 4'd3;
  localparam logic [3:0] S_P1   = 4'd4;
  localparam logic [3:0] S_P2   = 4'd5;
  localparam logic [3:0] S_P3   = 4'd6;
  localparam logic [3:0] S_P4   = 4'd7;
  localparam logic [3:0] S_DIVQ = 4'd8;
  localparam logic [3:0] S_GCD  = 4'd9;
  localparam logic [3:0] S_DIVN = 4'd10;
  localparam logic [3:0] S_DIVD = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;

  function automatic sm_t sm_make(input logic neg, input logic [MAG_W-1:0] mag);
    sm_t r;
    r.neg = neg && (mag != '0);
    r.mag = mag;
    return r;
  endfunction

  function automatic sm_t sm_add(input sm_t a, input sm_t b);
    sm_t r;
    if (a.neg == b.neg) r = sm_make(a.neg, a.mag + b.mag);
    else if (a.mag >= b.mag) r = sm_make(a.neg, a.mag - b.mag);
    else r = sm_make(b.neg, b.mag - a.mag);
    return r;
  endfunction

  function automatic sm_t sext_sm(input logic [15:0] v);
    logic [MAG_W-1:0] low;
    sm_t r;
    low = MAG_W'(v) & OW_MASK;
    if (low[OPERAND_WIDTH-1]) r = sm_make(1'b1, (OW_MASK - low) + MAG_W'(1));
    else r = sm_make(1'b0, low);
    return r;
  endfunction

  function automatic logic [MUL_W-1:0] read_den(input logic [14:0] v);
    logic [MAG_W-1:0] d;
    d = MAG_W'(v) & DEN_MASK;
    return (d == '0) ? MUL_W'(1) : d[MUL_W-1:0];
  endfunction

  logic [3:0]       state;
  logic [2:0]       act;
  sm_t              w1, w2, nm1, nm2, n1, n2, t1, t2, num;
  logic [MUL_W-1:0] d1, d2;
  logic [MAG_W-1:0] den, q, r, g, rn, rd;
  logic [MUL_W-1:0] mul_a, mul_b;
  logic [MAG_W-1:0] prod;
  logic             div_go, gcd_go;
  logic [MAG_W-1:0] div_n, div_d, div_q, div_r, gcd_g;
  logic             div_done, gcd_done;
  sm_t              n2_sum;
  logic             cmp_eq, cmp_lt, wide;
  rsp_t             idle_rsp, div0_rsp, cmp_rsp, fin_rsp;

  mfa_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  mfa_div u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(div_n), .divisor(div_d),
    .quotient(div_q), .remainder(div_r), .done(div_done)
  );

  mfa_gcd u_gcd (
    .clk(clk), .rst(rst), .go(gcd_go), .a(r), .b(den), .g(gcd_g), .done(gcd_done)
  );

  assign busy = (state != S_IDLE);

  // Multiplier operands for each step of the sequence.
  always_comb begin
    mul_a = d1;
    mul_b = d2;
    case (state)
      S_MW1: begin
        mul_a = w1.mag[MUL_W-1:0];
        mul_b = d1;
      end
      S_MW2: begin
        mul_a = w2.mag[MUL_W-1:0];
        mul_b = d2;
      end
      S_P1: begin
        mul_a = n1.mag[MUL_W-1:0];
        mul_b = (act == ACT_MUL) ? n2.mag[MUL_W-1:0] : d2;
      end
      S_P2: begin
        if (act == ACT_MUL) begin
          mul_a = d1;
          mul_b = d2;
        end else if (act == ACT_DIV) begin
          mul_a = d1;
          mul_b = n2.mag[MUL_W-1:0];
        end else begin
          mul_a = n2.mag[MUL_W-1:0];
          mul_b = d1;
        end
      end
      default: begin
        mul_a = d1;
        mul_b = d2;
      end
    endcase
  end

  // Divider operands for its three passes.
  always_comb begin
    case (state)
      S_DIVN: begin
        div_n = r;
        div_d = g;
      end
      S_DIVD: begin
        div_n = den;
        div_d = g;
      end
      default: begin
        div_n = num.mag;
        div_d = den;
      end
    endcase
  end

  // Compare flags, the overflow test and the result words.
  always_comb begin
    n2_sum = sm_add(sm_make(w2.neg, prod), nm2);
    cmp_eq = (t1.neg == t2.neg) && (t1.mag == t2.mag);
    if (t1.neg != t2.neg) cmp_lt = t1.neg;
    else if (t1.neg) cmp_lt = (t1.mag > t2.mag);
    else cmp_lt = (t1.mag < t2.mag);
    wide = num.neg ? (q > LIM_P1) : (q > LIM);
    idle_rsp = '0;
    idle_rsp.res_den = 31'd1;
    idle_rsp.status  = ST_OK;
    div0_rsp = idle_rsp;
    div0_rsp.status = ST_DIV0;
    cmp_rsp = idle_rsp;
    cmp_rsp.is_less    = cmp_lt;
    cmp_rsp.is_equal   = cmp_eq;
    cmp_rsp.is_greater = !cmp_lt && !cmp_eq;
    fin_rsp = idle_rsp;
    if (wide || rd > LIM) begin
      fin_rsp.status = ST_OVF;
    end else begin
      fin_rsp.res_whole = num.neg ? 32'(~q + MAG_W'(1)) : q[31:0];
      fin_rsp.res_num   = num.neg ? 32'(~rn + MAG_W'(1)) : rn[31:0];
      fin_rsp.res_den   = rd[30:0];
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      div_go <= 1'b0;
      gcd_go <= 1'b0;
    end else begin
      done   <= 1'b0;
      div_go <= 1'b0;
      gcd_go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            act   <= req.action;
            w1    <= sext_sm(req.left_whole);
            nm1   <= sext_sm(req.left_num);
            d1    <= read_den(req.left_den);
            w2    <= sext_sm(req.right_whole);
            nm2   <= sext_sm(req.right_num);
            d2    <= read_den(req.right_den);
            state <= S_MW1;
          end
        end
        S_MW1: state <= S_MW2;
        S_MW2: begin
          n1    <= sm_add(sm_make(w1.neg, prod), nm1);
          state <= S_MW3;
        end
        S_MW3: begin
          n2    <= (act == ACT_SUB) ? sm_make(!n2_sum.neg, n2_sum.mag) : n2_sum;
          state <= S_P1;
        end
        S_P1: begin
          // Divide by zero and unknown actions leave early.
          if (act == ACT_DIV && n2.mag == '0) begin
            rsp   <= div0_rsp;
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (act == ACT_ADD || act == ACT_SUB || act == ACT_MUL ||
                       act == ACT_DIV || act == ACT_CMP) begin
            state <= S_P2;
          end else begin
            rsp   <= idle_rsp;
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_P2: begin
          if (act == ACT_MUL || act == ACT_DIV) t1 <= sm_make(n1.neg ^ n2.neg, prod);
          else t1 <= sm_make(n1.neg, prod);
          state <= S_P3;
        end
        S_P3: begin
          if (act == ACT_MUL || act == ACT_DIV) t2 <= sm_make(1'b0, prod);
          else t2 <= sm_make(n2.neg, prod);
          state <= S_P4;
        end
        S_P4: begin
          if (act == ACT_CMP) begin
            rsp   <= cmp_rsp;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            if (act == ACT_ADD || act == ACT_SUB) begin
              num <= sm_add(t1, t2);
              den <= prod;
            end else begin
              num <= t1;
              den <= t2.mag;
            end
            div_go <= 1'b1;
            state  <= S_DIVQ;
          end
        end
        S_DIVQ: begin
          if (div_done) begin
            q      <= div_q;
            r      <= div_r;
            gcd_go <= 1'b1;
            state  <= S_GCD;
          end
        end
        S_GCD: begin
          if (gcd_done) begin
            g      <= gcd_g;
            div_go <= 1'b1;
            state  <= S_DIVN;
          end
        end
        S_DIVN: begin
          if (div_done) begin
            rn     <= div_q;
            div_go <= 1'b1;
            state  <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (div_done) begin
            rd    <= div_q;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          rsp   <= fin_rsp;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result word always ends the job, and busy is already low while it is shown.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result shown while still busy");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted word did not start a job");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.res_den != '0)) else $error("zero result denominator");

  a_flags_onehot: assert property (@(posedge clk) disable iff (rst)
    done |-> $onehot0({rsp.is_less, rsp.is_equal, rsp.is_greater}))
    else $error("more than one compare flag set");

endmodule

// ===== tb/mixed_fraction_alu_test.sv =====
// ----------------------------------------------------------------------------
// mixed_fraction_alu_test
// Self-checking bench for the mixed fraction unit. A directed table covers
// operand extremes, every action, zero denominators, divide by zero and
// unknown actions; random words follow. Every result word is compared
// field by field with a behavioral prediction held in a queue.
// ----------------------------------------------------------------------------
module mixed_fraction_alu_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mfa_pkg::*;

  localparam int N_RANDOM  = 1200;
  localparam int MAX_CYCLE = 1500000;
  localparam logic [2:0] ACT_BAD_LO  = 3'd5;
  localparam logic [2:0] ACT_BAD_MID = 3'd6;
  localparam logic [2:0] ACT_BAD     = 3'd7;

  logic  clk;
  logic  rst;
  logic  start;
  req_t  req;
  logic  busy;
  logic  done;
  rsp_t  rsp;

  rsp_t  expected_words[$];
  int    mismatch_count;
  int    cycle_count;
  bit    calm;

  mixed_fraction_alu uut (
    .clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .done(done), .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A known-value result word with the given status.
  function automatic rsp_t blank_word(logic [1:0] st);
    rsp_t r;
    r = '0;
    r.res_den = 31'd1;
    r.status = st;
    return r;
  endfunction

  // Exact rational result of one request word, using signed 64-bit and 128-bit math.
  function automatic rsp_t fraction_result(req_t q);
    rsp_t r;
    longint d1, d2, n1, n2, den, qt, rm, a, b, t, g;
    logic signed [127:0] num, lhs, rhs;
    longint lim;
    r = blank_word(ST_OK);
    lim = 64'h7FFFFFFF;
    d1 = (q.left_den == 0) ? 1 : q.left_den;
    d2 = (q.right_den == 0) ? 1 : q.right_den;
    n1 = longint'(q.left_whole) * d1 + longint'(q.left_num);
    n2 = longint'(q.right_whole) * d2 + longint'(q.right_num);
    case (q.action)
      ACT_ADD: begin num = n1 * d2 + n2 * d1; den = d1 * d2; end
      ACT_SUB: begin num = n1 * d2 - n2 * d1; den = d1 * d2; end
      ACT_MUL: begin num = n1 * n2; den = d1 * d2; end
      ACT_DIV: begin
        if (n2 == 0) return blank_word(ST_DIV0);
        num = (n2 < 0) ? -(n1 * d2) : n1 * d2;
        den = d1 * ((n2 < 0) ? -n2 : n2);
      end
      ACT_CMP: begin
        lhs = n1 * d2;
        rhs = n2 * d1;
        r.is_less = lhs < rhs;
        r.is_equal = lhs == rhs;
        r.is_greater = lhs > rhs;
        return r;
      end
      default: return r;
    endcase
    qt = num / den;
    rm = num % den;
    a = (rm < 0) ? -rm : rm;
    b = den;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    g = a;
    if (qt > lim || qt < -lim - 1 || den / g > lim) return blank_word(ST_OVF);
    r.res_whole = qt[31:0];
    r.res_num = 32'(rm / g);
    r.res_den = 31'(den / g);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // Check each result word against the oldest prediction.
  always @(posedge clk) begin
    rsp_t w;
    cycle_count <= cycle_count + 1;
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        w = expected_words.pop_front();
        if (rsp.res_whole !== w.res_whole) report_mismatch("res_whole", rsp.res_whole, w.res_whole);
        if (rsp.res_num !== w.res_num) report_mismatch("res_num", rsp.res_num, w.res_num);
        if (rsp.res_den !== w.res_den) report_mismatch("res_den", rsp.res_den, w.res_den);
        if (rsp.is_less !== w.is_less) report_mismatch("is_less", rsp.is_less, w.is_less);
        if (rsp.is_equal !== w.is_equal) report_mismatch("is_equal", rsp.is_equal, w.is_equal);
        if (rsp.is_greater !== w.is_greater) begin
          report_mismatch("is_greater", rsp.is_greater, w.is_greater);
        end
        if (rsp.status !== w.status) report_mismatch("status", rsp.status, w.status);
      end
    end
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    if (cycle_count > MAX_CYCLE) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Present one word, holding start until it is taken. Start stays high
  // between back-to-back words and drops only for an idle gap.
  task automatic send_word(req_t q, rsp_t want, bit typed);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req <= q;
    do @(posedge clk); while (busy);
    expected_words.push_back(typed ? want : fraction_result(q));
  endtask

  function automatic req_t make_req(logic [2:0] act, int lw, int ln, int ld,
                                    int rw, int rn, int rd);
    req_t q;
    q.action = act;
    q.left_whole = 16'(lw); q.left_num = 16'(ln); q.left_den = 15'(ld);
    q.right_whole = 16'(rw); q.right_num = 16'(rn); q.right_den = 15'(rd);
    return q;
  endfunction

  // Operand field with extremes weighted in.
  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 6)) - 16'd3;
      3: return 16'($urandom_range(0, 40)) - 16'd20;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [14:0] pick_den();
    case ($urandom_range(0, 4))
      0: return 15'($urandom_range(0, 2));
      1: return 15'h7FFF;
      2: return 15'($urandom_range(1, 30));
      default: return 15'($urandom);
    endcase
  endfunction

  req_t stim_table[$];
  rsp_t want_table[$];
  bit   typed_table[$];

  task automatic add_row(req_t q, rsp_t w, bit typed);
    stim_table.push_back(q);
    want_table.push_back(w);
    typed_table.push_back(typed);
  endtask

  initial begin
    req_t q;
    rsp_t w;
    int   act;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    mismatch_count = 0;
    cycle_count = 0;
    calm = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed rows; those with a typed result are plain by inspection.
    add_row(make_req(ACT_ADD, 0, 0, 0, 0, 0, 0), blank_word(ST_OK), 1);
    w = blank_word(ST_OK); w.res_whole = 3;
    add_row(make_req(ACT_ADD, 1, 0, 1, 2, 0, 0), w, 1);
    add_row(make_req(ACT_SUB, 1, 1, 2, 0, 1, 3), w, 0);
    add_row(make_req(ACT_MUL, -32768, -32768, 32767, 32767, 32767, 32767), w, 0);
    add_row(make_req(ACT_MUL, -32768, 0, 1, -32768, 0, 1), w, 0);
    add_row(make_req(ACT_ADD, 32767, 32767, 1, 32767, 32767, 1), w, 0);
    add_row(make_req(ACT_DIV, 5, 1, 2, 0, 0, 7), blank_word(ST_DIV0), 1);
    add_row(make_req(ACT_DIV, 5, 1, 2, 1, -3, 3), blank_word(ST_DIV0), 1);
    add_row(make_req(ACT_DIV, -32768, -32768, 1, 0, 1, 32767), w, 0);
    add_row(make_req(ACT_DIV, 1, 0, 1, 0, 1, 32767), w, 0);
    add_row(make_req(ACT_DIV, -7, -1, 3, 2, 1, 5), w, 0);
    add_row(make_req(ACT_SUB, 0, 1, 32767, 0, 1, 32766), w, 0);
    add_row(make_req(ACT_MUL, 0, 1, 32767, 0, 1, 32766), w, 0);
    add_row(make_req(ACT_MUL, 0, 0, 0, 0, 0, 0), blank_word(ST_OK), 1);
    w = blank_word(ST_OK); w.is_equal = 1'b1;
    add_row(make_req(ACT_CMP, 1, 1, 2, 0, 3, 2), w, 1);
    w = blank_word(ST_OK); w.is_less = 1'b1;
    add_row(make_req(ACT_CMP, -32768, 0, 1, 32767, 0, 1), w, 1);
    w = blank_word(ST_OK); w.is_greater = 1'b1;
    add_row(make_req(ACT_CMP, 0, 1, 0, 0, -1, 0), w, 1);
    add_row(make_req(ACT_BAD_LO, 1, 2, 3, 4, 5, 6), blank_word(ST_OK), 1);
    add_row(make_req(ACT_BAD_MID, -1, -1, 32767, -1, -1, 32767), blank_word(ST_OK), 1);
    add_row(make_req(ACT_BAD, 0, 0, 0, 0, 0, 0), blank_word(ST_OK), 1);
    foreach (stim_table[i]) send_word(stim_table[i], want_table[i], typed_table[i]);

    // Random words, mostly legal actions; the last stretch runs without gaps.
    for (int i = 0; i < N_RANDOM; i++) begin
      calm = (i > N_RANDOM - 150);
      act = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
      q.action = act[2:0];
      q.left_whole = pick16(); q.left_num = pick16(); q.left_den = pick_den();
      q.right_whole = pick16(); q.right_num = pick16(); q.right_den = pick_den();
      if ($urandom_range(0, 9) == 0) begin
        q.right_whole = '0; q.right_num = '0;
      end
      send_word(q, w, 0);
    end
    start <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
